// File: design/ebls_pkg.sv
// Shared types, widths and register constants for the energy bucket load switcher.
`timescale 1ns / 1ps
package ebls_pkg;
	localparam int ENERGY_W   = 24;
	localparam int MASK_W     = 3;
	localparam int SETTLE_W   = 8;
	localparam int LEVEL_W    = ENERGY_W + 2;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_CAPACITY  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOWER_DEF = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_UPPER_DEF = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SETTLE    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROT_EN    = 3'd4;

	localparam logic [ENERGY_W-1:0] CAPACITY_RST  = 24'd180000;
	localparam logic [ENERGY_W-1:0] LOWER_DEF_RST = 24'd90000;
	localparam logic [ENERGY_W-1:0] UPPER_DEF_RST = 24'd90000;
	localparam logic [SETTLE_W-1:0] SETTLE_RST    = 8'd3;
	localparam logic                ROT_EN_RST    = 1'b1;

	typedef struct packed {
		logic [ENERGY_W-1:0] capacity;
		logic [ENERGY_W-1:0] lower_def;
		logic [ENERGY_W-1:0] upper_def;
		logic [SETTLE_W-1:0] settle;
		logic                rot_en;
	} cfg_t;

	typedef struct packed {
		logic signed [ENERGY_W-1:0] energy_delta;
		logic                       rotate_priorities;
		logic                       diversion_off;
		logic [MASK_W-1:0]          override_mask;
	} item_t;

	typedef struct packed {
		logic [MASK_W-1:0]   load_on_mask;
		logic [MASK_W-1:0]   logical_on_mask;
		logic [ENERGY_W-1:0] energy_level;
		logic                switched;
	} res_t;
endpackage

// File: design/ebls_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface ebls_item_if import ebls_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [ENERGY_W-1:0] energy_delta;
	logic                       rotate_priorities;
	logic                       diversion_off;
	logic [MASK_W-1:0]          override_mask;

	modport source (output valid, energy_delta, rotate_priorities, diversion_off,
		override_mask, input ready);
	modport sink (input valid, energy_delta, rotate_priorities, diversion_off,
		override_mask, output ready);
endinterface

interface ebls_result_if import ebls_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MASK_W-1:0]   load_on_mask;
	logic [MASK_W-1:0]   logical_on_mask;
	logic [ENERGY_W-1:0] energy_level;
	logic                switched;

	modport source (output valid, load_on_mask, logical_on_mask, energy_level, switched,
		input ready);
	modport sink (input valid, load_on_mask, logical_on_mask, energy_level, switched,
		output ready);
endinterface

// File: design/ebls_cfg.sv
// APB configuration register file for the energy bucket load switcher.
`timescale 1ns / 1ps
module ebls_cfg import ebls_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);
	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity  <= CAPACITY_RST;
			cfg_q.lower_def <= LOWER_DEF_RST;
			cfg_q.upper_def <= UPPER_DEF_RST;
			cfg_q.settle    <= SETTLE_RST;
			cfg_q.rot_en    <= ROT_EN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_CAPACITY:  cfg_q.capacity  <= pwdata[ENERGY_W-1:0];
				REG_LOWER_DEF: cfg_q.lower_def <= pwdata[ENERGY_W-1:0];
				REG_UPPER_DEF: cfg_q.upper_def <= pwdata[ENERGY_W-1:0];
				REG_SETTLE:    cfg_q.settle    <= pwdata[SETTLE_W-1:0];
				REG_ROT_EN:    cfg_q.rot_en    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CAPACITY:  prdata = {{(APB_DATA_W-ENERGY_W){1'b0}}, cfg_q.capacity};
			REG_LOWER_DEF: prdata = {{(APB_DATA_W-ENERGY_W){1'b0}}, cfg_q.lower_def};
			REG_UPPER_DEF: prdata = {{(APB_DATA_W-ENERGY_W){1'b0}}, cfg_q.upper_def};
			REG_SETTLE:    prdata = {{(APB_DATA_W-SETTLE_W){1'b0}}, cfg_q.settle};
			REG_ROT_EN:    prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.rot_en};
			default:       prdata = '0;
		endcase
	end
endmodule

// File: design/ebls_step.sv
// Bucket state, hysteresis decision, priority rotation and load mapping for one item.
`timescale 1ns / 1ps
module ebls_step import ebls_pkg::*; #(
	parameter int NUM_LOADS = 3
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  fire,
	input  item_t item,
	output res_t  res
);
	localparam int LOAD_W = (NUM_LOADS > 1) ? $clog2(NUM_LOADS) : 1;
	localparam int POS_W  = $clog2(NUM_LOADS + 1);
	localparam logic [POS_W-1:0] POS_NONE = POS_W'(NUM_LOADS);

	logic [ENERGY_W-1:0] level_q;
	logic [ENERGY_W-1:0] lower_thr_q;
	logic [ENERGY_W-1:0] upper_thr_q;
	logic                recent_q;
	logic [SETTLE_W-1:0] since_q;
	logic [POS_W-1:0]    active_q;
	logic [LOAD_W-1:0]   order_q [NUM_LOADS];
	logic [NUM_LOADS-1:0] on_q;

	logic signed [LEVEL_W-1:0] level;
	logic signed [LEVEL_W-1:0] cap_x;
	logic signed [LEVEL_W:0]   level2;
	logic                      upper_half;
	logic [SETTLE_W-1:0]       since_inc;
	logic                      recent_now;
	logic [POS_W-1:0]          first_off;
	logic [POS_W-1:0]          last_on;
	logic                      found_off;
	logic                      found_on;
	logic                      ok;
	logic                      sw;
	logic [ENERGY_W-1:0]       lower_n;
	logic [ENERGY_W-1:0]       upper_n;
	logic                      recent_n;
	logic [SETTLE_W-1:0]       since_n;
	logic [POS_W-1:0]          active_n;
	logic [NUM_LOADS-1:0]      on_n;
	logic [NUM_LOADS-1:0]      on_r;
	logic [LOAD_W-1:0]         order_n [NUM_LOADS];
	logic [MASK_W-1:0]         phys;
	logic [MASK_W-1:0]         logm;
	logic [ENERGY_W-1:0]       level_clamp;

	assign level  = $signed({2'b00, level_q}) + $signed({{2{item.energy_delta[ENERGY_W-1]}},
		item.energy_delta});
	assign cap_x  = $signed({2'b00, cfg.capacity});
	assign level2 = {level, 1'b0};
	assign upper_half = level2 > $signed({3'b000, cfg.capacity});
	assign since_inc  = (since_q != {SETTLE_W{1'b1}}) ? since_q + 1'b1 : since_q;
	assign recent_now = recent_q && (since_inc < cfg.settle);
	assign found_off  = ~&on_q;
	assign found_on   = |on_q;

	always_comb begin
		first_off = POS_NONE;
		last_on   = POS_NONE;
		for (int i = NUM_LOADS - 1; i >= 0; i--) begin
			if (!on_q[i]) first_off = POS_W'(i);
		end
		for (int i = 0; i < NUM_LOADS; i++) begin
			if (on_q[i]) last_on = POS_W'(i);
		end
	end

	always_comb begin
		lower_n  = lower_thr_q;
		upper_n  = upper_thr_q;
		recent_n = recent_now;
		since_n  = since_inc;
		active_n = active_q;
		on_n     = on_q;
		ok       = 1'b0;
		sw       = 1'b0;
		if (upper_half) begin
			lower_n = cfg.lower_def;
			if ((level > $signed({2'b00, upper_thr_q})) && found_off) begin
				ok = 1'b1;
				if (recent_now) begin
					upper_n = (level > cap_x) ? cfg.capacity : level[ENERGY_W-1:0];
					ok      = (first_off == active_q);
				end
				if (ok) begin
					for (int i = 0; i < NUM_LOADS; i++) begin
						if (POS_W'(i) == first_off) on_n[i] = 1'b1;
					end
					active_n = first_off;
					since_n  = '0;
					recent_n = 1'b1;
					sw       = 1'b1;
				end
			end
		end else begin
			upper_n = cfg.upper_def;
			if ((level < $signed({2'b00, lower_thr_q})) && found_on) begin
				ok = 1'b1;
				if (recent_now) begin
					lower_n = level[LEVEL_W-1] ? '0 : level[ENERGY_W-1:0];
					ok      = (last_on == active_q);
				end
				if (ok) begin
					for (int i = 0; i < NUM_LOADS; i++) begin
						if (POS_W'(i) == last_on) on_n[i] = 1'b0;
					end
					active_n = last_on;
					since_n  = '0;
					recent_n = 1'b1;
					sw       = 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LOADS; i++) begin
			order_n[i] = order_q[i];
			on_r[i]    = on_n[i];
		end
		if (item.rotate_priorities && cfg.rot_en) begin
			order_n[0] = order_q[NUM_LOADS-1];
			on_r[0]    = on_n[NUM_LOADS-1];
			for (int i = 1; i < NUM_LOADS; i++) begin
				order_n[i] = order_q[i-1];
				on_r[i]    = on_n[i-1];
			end
		end
	end

	always_comb begin
		phys = '0;
		logm = '0;
		for (int i = 0; i < NUM_LOADS; i++) begin
			if (i < MASK_W) logm[i] = on_r[i];
			for (int k = 0; k < MASK_W; k++) begin
				if ((int'(order_n[i]) == k) && !item.diversion_off
					&& (item.override_mask[k] || on_r[i])) begin
					phys[k] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (level > cap_x) level_clamp = cfg.capacity;
		else if (level[LEVEL_W-1]) level_clamp = '0;
		else level_clamp = level[ENERGY_W-1:0];
	end

	assign res.load_on_mask    = phys;
	assign res.logical_on_mask = logm;
	assign res.energy_level    = level_clamp;
	assign res.switched        = sw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			lower_thr_q <= LOWER_DEF_RST;
			upper_thr_q <= UPPER_DEF_RST;
			recent_q    <= 1'b0;
			since_q     <= '0;
			active_q    <= POS_NONE;
			on_q        <= '0;
			for (int i = 0; i < NUM_LOADS; i++) begin
				order_q[i] <= LOAD_W'(i);
			end
		end else if (fire) begin
			level_q     <= level_clamp;
			lower_thr_q <= lower_n;
			upper_thr_q <= upper_n;
			recent_q    <= recent_n;
			since_q     <= since_n;
			active_q    <= active_n;
			on_q        <= on_r;
			for (int i = 0; i < NUM_LOADS; i++) begin
				order_q[i] <= order_n[i];
			end
		end
	end
endmodule

// File: design/energy_bucket_load_switcher_core.sv
// Energy bucket load switcher: top level with input register, step logic and result register.
// One transaction per mains cycle: an item enters an input register, the bucket add,
// threshold compares and priority encoders settle the state and the result, and the
// result waits in an output register. The block takes one item every cycle while the
// result output is not stalled, set by the state update loop through the bucket
// adder, the hysteresis compare and the on/off priority encoders. Configuration
// goes through the APB port at byte address 4*index and should be written while idle.
`timescale 1ns / 1ps
module energy_bucket_load_switcher_core import ebls_pkg::*; #(
	parameter int NUM_LOADS = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ebls_item_if.sink             item,
	ebls_result_if.source         result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_next;
	res_t  res_q;
	logic  res_valid_q;
	logic  advance;
	logic  take;

	ebls_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ebls_step #(.NUM_LOADS(NUM_LOADS)) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (advance),
		.item   (item_s1),
		.res    (res_next)
	);

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.energy_delta      <= item.energy_delta;
			item_s1.rotate_priorities <= item.rotate_priorities;
			item_s1.diversion_off     <= item.diversion_off;
			item_s1.override_mask     <= item.override_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res_next;
	end

	assign result.valid           = res_valid_q;
	assign result.load_on_mask    = res_q.load_on_mask;
	assign result.logical_on_mask = res_q.logical_on_mask;
	assign result.energy_level    = res_q.energy_level;
	assign result.switched        = res_q.switched;
endmodule
